>>> design/bsri_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsri_pkg;

    localparam int LOCATIONS       = 16;
    localparam int LEVELS          = 8;
    localparam int MEMBERS         = 1024;
    localparam int BUCKET_CAPACITY = 256;

    localparam int NUM_BUCKETS = LOCATIONS * LEVELS;
    localparam int NUM_SLOTS   = NUM_BUCKETS * BUCKET_CAPACITY;

    localparam int CMD_W    = 2;
    localparam int MEMBER_W = $clog2(MEMBERS);
    localparam int LOC_W    = $clog2(LOCATIONS);
    localparam int LEVEL_W  = $clog2(LEVELS);
    localparam int SLOT_W   = $clog2(BUCKET_CAPACITY);
    localparam int BUCKET_W = LOC_W + LEVEL_W;
    localparam int ADDR_W   = BUCKET_W + SLOT_W;
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_PRESENT = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // per-member record: presence, bucket and slot in one word
    typedef struct packed {
        logic                present;
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
    } t_rec;

endpackage

`default_nettype wire

>>> design/bsri_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsri_in_if;
    import bsri_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [MEMBER_W-1:0] person_id;
    logic [LOC_W-1:0]    location;
    logic [LEVEL_W-1:0]  level;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, command, person_id, location, level, slot, input ready);
    modport sink (input valid, command, person_id, location, level, slot, output ready);
endinterface

interface bsri_out_if;
    import bsri_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [MEMBER_W-1:0] member_out;
    logic [SLOT_W-1:0]   slot_out;
    logic [COUNT_W-1:0]  bucket_count;

    modport source (output valid, status, member_out, slot_out, bucket_count, input ready);
    modport sink (input valid, status, member_out, slot_out, bucket_count, output ready);
endinterface

`default_nettype wire

>>> design/bucketed_swap_remove_index_core.sv
`timescale 1ns / 1ps
`default_nettype none
// add, read and errors go from input accept through the lookup state to the result register;
// remove and move also pass count read, last-slot read, swap write and place write
// a new item is taken only once the last result has moved to the output register, so a
// held output also stalls input; the reads of the member, count and slot memories are registered
// reset: synchronous active low; afterwards a sweep over all member ids clears member records
// and bucket counts, with input ready held low until it ends

module bucketed_swap_remove_index_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsri_in_if.sink    i_in,
    bsri_out_if.source o_out
);
    import bsri_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(BUCKET_CAPACITY);
    localparam logic [COUNT_W-1:0] ONE_CNT = COUNT_W'(1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_LAST  = 7'b0001000,
        S_SWAP  = 7'b0010000,
        S_PLACE = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // memories
    logic [MEMBER_W-1:0] slot_mem [NUM_SLOTS];
    logic [COUNT_W-1:0]  cnt_mem  [NUM_BUCKETS];
    t_rec                rec_mem  [MEMBERS];

    logic [MEMBER_W-1:0] slot_rd;
    logic [COUNT_W-1:0]  cnt_rd;
    t_rec                rec_rd;

    logic                slot_we;
    logic [ADDR_W-1:0]   slot_wa;
    logic [MEMBER_W-1:0] slot_wd;
    logic [ADDR_W-1:0]   slot_ra;
    logic                cnt_we;
    logic [BUCKET_W-1:0] cnt_wa;
    logic [COUNT_W-1:0]  cnt_wd;
    logic [BUCKET_W-1:0] cnt_ra;
    logic                rec_we;
    logic [MEMBER_W-1:0] rec_wa;
    t_rec                rec_wd;

    t_state              r_state, n_state;
    logic [MEMBER_W-1:0] r_clr;
    t_cmd                r_cmd;
    logic [MEMBER_W-1:0] r_pid;
    logic [BUCKET_W-1:0] r_tb;
    logic [SLOT_W-1:0]   r_rs;
    logic [BUCKET_W-1:0] r_ob;
    logic [SLOT_W-1:0]   r_os;
    logic [COUNT_W-1:0]  r_cnt_t;
    logic [COUNT_W-1:0]  r_n;
    logic                r_degen;
    logic [MEMBER_W-1:0] r_filler;

    t_status             r_res_status, res_status;
    logic [MEMBER_W-1:0] r_res_mo, res_mo;
    logic [SLOT_W-1:0]   r_res_so, res_so;
    logic [COUNT_W-1:0]  r_res_cnt, res_cnt;
    logic                res_ld;

    logic                r_ov;
    t_status             r_o_status;
    logic [MEMBER_W-1:0] r_o_mo;
    logic [SLOT_W-1:0]   r_o_so;
    logic [COUNT_W-1:0]  r_o_cnt;

    logic                in_acc;
    logic [BUCKET_W-1:0] in_bucket;
    logic [COUNT_W-1:0]  cnt_dec;
    logic                cnt_full;
    logic                degen;
    logic [COUNT_W-1:0]  place_n;
    logic                out_free;

    assign in_acc    = i_in.valid && i_in.ready;
    assign in_bucket = {i_in.location, i_in.level};
    assign cnt_dec   = cnt_rd - ONE_CNT;
    assign cnt_full  = cnt_rd >= CAP_CNT;
    assign degen     = (cnt_rd == '0) || (cnt_rd > CAP_CNT) || ({1'b0, r_os} >= cnt_rd);
    assign place_n   = r_degen ? r_cnt_t : ((r_ob == r_tb) ? (r_n - ONE_CNT) : r_cnt_t);
    assign out_free  = !r_ov || o_out.ready;

    assign cnt_ra  = (r_state == S_IDLE) ? in_bucket : rec_rd.bucket;
    assign slot_ra = (r_state == S_IDLE) ? {in_bucket, i_in.slot}
                                         : {r_ob, cnt_dec[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd <= slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rec_rd <= rec_mem[i_in.person_id];
    end

    always_comb begin
        n_state    = r_state;
        slot_we    = 1'b0;
        slot_wa    = {r_tb, r_rs};
        slot_wd    = r_pid;
        cnt_we     = 1'b0;
        cnt_wa     = r_tb;
        cnt_wd     = '0;
        rec_we     = 1'b0;
        rec_wa     = r_pid;
        rec_wd     = '0;
        res_ld     = 1'b0;
        res_status = ST_OK;
        res_mo     = '0;
        res_so     = '0;
        res_cnt    = '0;
        case (r_state)
            S_CLEAR: begin
                cnt_we = 1'b1;
                cnt_wa = r_clr[BUCKET_W-1:0];
                rec_we = 1'b1;
                rec_wa = r_clr;
                if (r_clr == MEMBER_W'(MEMBERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                case (r_cmd)
                    CMD_READ: begin
                        res_ld  = 1'b1;
                        res_cnt = cnt_rd;
                        if ({1'b0, r_rs} < cnt_rd) begin
                            res_mo = slot_rd;
                        end else begin
                            res_status = ST_EMPTY;
                        end
                        n_state = S_DONE;
                    end
                    CMD_ADD: begin
                        res_ld  = 1'b1;
                        res_cnt = cnt_rd;
                        if (rec_rd.present) begin
                            res_status = ST_PRESENT;
                        end else if (cnt_full) begin
                            res_status = ST_FULL;
                        end else begin
                            slot_we = 1'b1;
                            slot_wa = {r_tb, cnt_rd[SLOT_W-1:0]};
                            cnt_we  = 1'b1;
                            cnt_wd  = cnt_rd + ONE_CNT;
                            rec_we  = 1'b1;
                            rec_wd  = '{present: 1'b1, bucket: r_tb,
                                        slot: cnt_rd[SLOT_W-1:0]};
                            res_so  = cnt_rd[SLOT_W-1:0];
                            res_cnt = cnt_rd + ONE_CNT;
                        end
                        n_state = S_DONE;
                    end
                    CMD_REMOVE, CMD_MOVE: begin
                        if (!rec_rd.present) begin
                            res_ld     = 1'b1;
                            res_status = ST_ABSENT;
                            n_state    = S_DONE;
                        end else if (r_cmd == CMD_MOVE && rec_rd.bucket != r_tb
                                     && cnt_full) begin
                            res_ld     = 1'b1;
                            res_status = ST_FULL;
                            res_cnt    = cnt_rd;
                            n_state    = S_DONE;
                        end else begin
                            n_state = S_LAST;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_LAST: begin
                // old bucket count is here; the last slot read is in flight
                n_state = degen ? S_PLACE : S_SWAP;
            end
            S_SWAP: begin
                slot_we = 1'b1;
                slot_wa = {r_ob, r_os};
                slot_wd = slot_rd;
                cnt_we  = 1'b1;
                cnt_wa  = r_ob;
                cnt_wd  = r_n - ONE_CNT;
                // filler keeps its bucket and takes over the freed slot
                rec_we  = slot_rd != r_pid;
                rec_wa  = slot_rd;
                rec_wd  = '{present: 1'b1, bucket: r_ob, slot: r_os};
                n_state = S_PLACE;
            end
            S_PLACE: begin
                res_ld = 1'b1;
                res_mo = r_filler;
                rec_we = 1'b1;
                if (r_cmd == CMD_MOVE) begin
                    slot_we = 1'b1;
                    slot_wa = {r_tb, place_n[SLOT_W-1:0]};
                    cnt_we  = 1'b1;
                    cnt_wd  = place_n + ONE_CNT;
                    rec_wd  = '{present: 1'b1, bucket: r_tb, slot: place_n[SLOT_W-1:0]};
                    res_so  = place_n[SLOT_W-1:0];
                    res_cnt = place_n + ONE_CNT;
                end else begin
                    rec_wd  = '{present: 1'b0, bucket: r_ob, slot: r_os};
                    res_cnt = r_degen ? r_n : (r_n - ONE_CNT);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + MEMBER_W'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= t_cmd'(i_in.command);
            r_pid <= i_in.person_id;
            r_tb  <= in_bucket;
            r_rs  <= i_in.slot;
        end
        if (r_state == S_LOOK) begin
            r_ob    <= rec_rd.bucket;
            r_os    <= rec_rd.slot;
            r_cnt_t <= cnt_rd;
        end
        if (r_state == S_LAST) begin
            r_n      <= cnt_rd;
            r_degen  <= degen;
            r_filler <= r_pid;
        end
        if (r_state == S_SWAP) begin
            r_filler <= slot_rd;
        end
        if (res_ld) begin
            r_res_status <= res_status;
            r_res_mo     <= res_mo;
            r_res_so     <= res_so;
            r_res_cnt    <= res_cnt;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_res_status;
            r_o_mo     <= r_res_mo;
            r_o_so     <= r_res_so;
            r_o_cnt    <= r_res_cnt;
        end
    end

    assign i_in.ready         = r_state == S_IDLE;
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_o_status;
    assign o_out.member_out   = r_o_mo;
    assign o_out.slot_out     = r_o_so;
    assign o_out.bucket_count = r_o_cnt;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> cnt_wd <= CAP_CNT)
        else $error("bucket count written above capacity");

    a_acc_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_LOOK)
        else $error("accepted item did not start a lookup");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_swap_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWAP |-> !r_degen && $past(r_state == S_LAST))
        else $error("swap entered without a valid last slot");

endmodule

`default_nettype wire

>>> tb/bucketed_swap_remove_index_core_tb.sv
`timescale 1ns / 1ps

module bucketed_swap_remove_index_core_tb;
    import bsri_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int FILL_AFTER   = 500;
    localparam int POP_LIMIT    = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TOP_BUCKET   = NUM_BUCKETS - 1;

    typedef struct packed {
        t_cmd                cmd;
        logic [MEMBER_W-1:0] person;
        logic [LOC_W-1:0]    loc;
        logic [LEVEL_W-1:0]  lvl;
        logic [SLOT_W-1:0]   slot;
    } t_request;

    typedef struct packed {
        t_status             status;
        logic [MEMBER_W-1:0] member;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    bsri_in_if  req_if();
    bsri_out_if rsp_if();

    bucketed_swap_remove_index_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // mirror of the index, updated on each accepted item
    logic [MEMBER_W-1:0] idx_slots [NUM_BUCKETS][BUCKET_CAPACITY];
    int idx_count     [NUM_BUCKETS];
    int idx_bucket_of [MEMBERS];
    int idx_slot_of   [MEMBERS];
    bit idx_present   [MEMBERS];

    // coarse view used only to steer stimulus while it is queued
    bit plan_present   [MEMBERS];
    int plan_bucket_of [MEMBERS];
    int plan_pos       [MEMBERS];
    int plan_count     [NUM_BUCKETS];
    int plan_members[$];
    int hot_buckets[4];

    t_request pending_requests[$];
    t_reply   predicted_replies[$];
    t_request next_req;
    t_reply   want_reply;

    int total_items;
    int accepted_count;
    int cycle_count;
    int fail_count;

    // swap-remove a present member, returns the member now in its old slot
    function automatic int take_out(int m);
        int b;
        int s;
        int n;
        int filler;
        b = idx_bucket_of[m];
        s = idx_slot_of[m];
        n = idx_count[b];
        idx_present[m] = 1'b0;
        if (n == 0 || s >= n)
            return m;
        filler = idx_slots[b][n-1];
        idx_slots[b][s] = MEMBER_W'(filler);
        idx_slot_of[filler] = s;
        idx_count[b] = n - 1;
        return filler;
    endfunction

    function automatic int put_in(int m, int b);
        int n;
        n = idx_count[b];
        idx_slots[b][n] = MEMBER_W'(m);
        idx_count[b] = n + 1;
        idx_bucket_of[m] = b;
        idx_slot_of[m] = n;
        idx_present[m] = 1'b1;
        return n;
    endfunction

    function automatic t_reply index_step(t_request req);
        int m;
        int tb;
        int ob;
        t_reply rep;
        m = int'(req.person);
        tb = int'(req.loc) * LEVELS + int'(req.lvl);
        rep = '0;
        rep.status = ST_OK;
        case (req.cmd)
            CMD_ADD: begin
                if (idx_present[m])
                    rep.status = ST_PRESENT;
                else if (idx_count[tb] >= BUCKET_CAPACITY)
                    rep.status = ST_FULL;
                else
                    rep.slot = SLOT_W'(put_in(m, tb));
                rep.count = COUNT_W'(idx_count[tb]);
            end
            CMD_REMOVE: begin
                if (!idx_present[m]) begin
                    rep.status = ST_ABSENT;
                end else begin
                    ob = idx_bucket_of[m];
                    rep.member = MEMBER_W'(take_out(m));
                    rep.count = COUNT_W'(idx_count[ob]);
                end
            end
            CMD_MOVE: begin
                if (!idx_present[m]) begin
                    rep.status = ST_ABSENT;
                end else if (idx_bucket_of[m] != tb && idx_count[tb] >= BUCKET_CAPACITY) begin
                    rep.status = ST_FULL;
                    rep.count = COUNT_W'(idx_count[tb]);
                end else begin
                    rep.member = MEMBER_W'(take_out(m));
                    rep.slot = SLOT_W'(put_in(m, tb));
                    rep.count = COUNT_W'(idx_count[tb]);
                end
            end
            default: begin
                rep.count = COUNT_W'(idx_count[tb]);
                if (int'(req.slot) < idx_count[tb])
                    rep.member = idx_slots[tb][req.slot];
                else
                    rep.status = ST_EMPTY;
            end
        endcase
        return rep;
    endfunction

    function automatic void drop_member(int m);
        int idx;
        int last;
        idx = plan_pos[m];
        last = plan_members[plan_members.size()-1];
        plan_members[idx] = last;
        plan_pos[last] = idx;
        plan_members.delete(plan_members.size() - 1);
        plan_present[m] = 1'b0;
    endfunction

    function automatic void plan_item(t_cmd cmd, int m, int b, int slot);
        t_request req;
        req.cmd = cmd;
        req.person = MEMBER_W'(m);
        req.loc = LOC_W'(b / LEVELS);
        req.lvl = LEVEL_W'(b % LEVELS);
        req.slot = SLOT_W'(slot);
        pending_requests.insert(pending_requests.size(), req);
        case (cmd)
            CMD_ADD: begin
                if (!plan_present[m] && plan_count[b] < BUCKET_CAPACITY) begin
                    plan_present[m] = 1'b1;
                    plan_bucket_of[m] = b;
                    plan_count[b]++;
                    plan_pos[m] = plan_members.size();
                    plan_members.insert(plan_members.size(), m);
                end
            end
            CMD_REMOVE: begin
                if (plan_present[m]) begin
                    plan_count[plan_bucket_of[m]]--;
                    drop_member(m);
                end
            end
            CMD_MOVE: begin
                if (plan_present[m] &&
                    (plan_bucket_of[m] == b || plan_count[b] < BUCKET_CAPACITY)) begin
                    plan_count[plan_bucket_of[m]]--;
                    plan_count[b]++;
                    plan_bucket_of[m] = b;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_absent();
        int m;
        do
            m = $urandom_range(MEMBERS - 1);
        while (plan_present[m]);
        return m;
    endfunction

    function automatic int pick_present();
        if (plan_members.size() == 0)
            return $urandom_range(MEMBERS - 1);
        return plan_members[$urandom_range(plan_members.size() - 1)];
    endfunction

    function automatic int pick_bucket();
        if ($urandom_range(99) < 70)
            return hot_buckets[$urandom_range(3)];
        return $urandom_range(NUM_BUCKETS - 1);
    endfunction

    function automatic void plan_random_item();
        int sel;
        int roll;
        int m;
        int b;
        sel = $urandom_range(99);
        roll = $urandom_range(99);
        if (sel < 35) begin
            if (roll < 85 && plan_members.size() < POP_LIMIT)
                m = pick_absent();
            else
                m = pick_present();
            plan_item(CMD_ADD, m, pick_bucket(), $urandom_range(255));
        end else if (sel < 60) begin
            m = (roll < 85) ? pick_present() : $urandom_range(MEMBERS - 1);
            plan_item(CMD_REMOVE, m, $urandom_range(NUM_BUCKETS - 1), $urandom_range(255));
        end else if (sel < 80) begin
            m = (roll < 85) ? pick_present() : $urandom_range(MEMBERS - 1);
            if (plan_present[m] && $urandom_range(99) < 20)
                b = plan_bucket_of[m];
            else
                b = pick_bucket();
            plan_item(CMD_MOVE, m, b, $urandom_range(255));
        end else begin
            b = pick_bucket();
            if (roll < 75 && plan_count[b] > 0)
                plan_item(CMD_READ, $urandom_range(MEMBERS - 1), b,
                          $urandom_range(plan_count[b] - 1));
            else
                plan_item(CMD_READ, $urandom_range(MEMBERS - 1), b, $urandom_range(255));
        end
    endfunction

    // brings one bucket to capacity, pokes at it, then thins it out again
    function automatic void fill_bucket(int b);
        int m;
        int tries;
        while (plan_count[b] < BUCKET_CAPACITY)
            plan_item(CMD_ADD, pick_absent(), b, $urandom_range(255));
        plan_item(CMD_ADD, pick_absent(), b, $urandom_range(255));
        plan_item(CMD_ADD, pick_present(), b, $urandom_range(255));
        tries = 0;
        do begin
            m = pick_present();
            tries++;
        end while (plan_bucket_of[m] == b && tries < 200);
        plan_item(CMD_MOVE, m, b, $urandom_range(255));
        do
            m = pick_present();
        while (plan_bucket_of[m] != b);
        plan_item(CMD_MOVE, m, b, $urandom_range(255));
        repeat (16)
            plan_item(CMD_READ, $urandom_range(MEMBERS - 1), b, $urandom_range(255));
        plan_item(CMD_READ, 0, b, BUCKET_CAPACITY - 1);
        repeat (128) begin
            do
                m = pick_present();
            while (plan_bucket_of[m] != b);
            if ($urandom_range(1))
                plan_item(CMD_REMOVE, m, b, $urandom_range(255));
            else
                plan_item(CMD_MOVE, m, pick_bucket(), $urandom_range(255));
        end
    endfunction

    function automatic int idle_pct(bit sender);
        if (accepted_count < total_items / 3)
            return sender ? 26 : 78;
        if (accepted_count < 2 * total_items / 3)
            return sender ? 78 : 26;
        return 0;
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() > 0 && int'($urandom_range(99)) >= idle_pct(1'b1)) begin
                next_req = pending_requests.pop_front();
                req_if.valid     <= 1'b1;
                req_if.command   <= next_req.cmd;
                req_if.person_id <= next_req.person;
                req_if.location  <= next_req.loc;
                req_if.level     <= next_req.lvl;
                req_if.slot      <= next_req.slot;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predicted_replies.insert(predicted_replies.size(),
                                     index_step({t_cmd'(req_if.command), req_if.person_id,
                                                 req_if.location, req_if.level,
                                                 req_if.slot}));
            accepted_count <= accepted_count + 1;
        end
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= i_rst_n && (int'($urandom_range(99)) >= idle_pct(1'b0));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            if (predicted_replies.size() == 0) begin
                $display("%0t: reply with none expected, status %0d member %0d", $time,
                         rsp_if.status, rsp_if.member_out);
                fail_count++;
            end else begin
                want_reply = predicted_replies.pop_front();
                check_field("status", want_reply.status, rsp_if.status);
                check_field("member_out", want_reply.member, rsp_if.member_out);
                check_field("slot_out", want_reply.slot, rsp_if.slot_out);
                check_field("bucket_count", want_reply.count, rsp_if.bucket_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int directed_count;
        int random_planned;
        bit filled;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.command   = CMD_ADD;
        req_if.person_id = '0;
        req_if.location  = '0;
        req_if.level     = '0;
        req_if.slot      = '0;
        rsp_if.ready     = 1'b0;
        accepted_count   = 0;
        cycle_count      = 0;
        fail_count       = 0;
        filled           = 1'b0;

        hot_buckets[0] = 0;
        hot_buckets[1] = TOP_BUCKET;
        hot_buckets[2] = $urandom_range(1, NUM_BUCKETS - 2);
        hot_buckets[3] = $urandom_range(NUM_BUCKETS - 1);

        // empty index, absent members, extremes of id and bucket
        plan_item(CMD_READ, 0, 0, 0);
        plan_item(CMD_REMOVE, 0, 0, 0);
        plan_item(CMD_MOVE, MEMBERS - 1, TOP_BUCKET, 255);
        plan_item(CMD_ADD, 0, 0, 0);
        plan_item(CMD_ADD, MEMBERS - 1, TOP_BUCKET, 255);
        plan_item(CMD_ADD, 0, TOP_BUCKET, 0);
        plan_item(CMD_ADD, 5, 0, 0);
        plan_item(CMD_ADD, 6, 0, 0);
        plan_item(CMD_READ, 0, 0, 1);
        plan_item(CMD_READ, 0, 0, 255);
        // swap-remove from the front, then the last slot fills itself
        plan_item(CMD_REMOVE, 0, 0, 0);
        plan_item(CMD_READ, 0, 0, 0);
        plan_item(CMD_REMOVE, 5, 0, 0);
        // move within the same bucket ends in the last slot
        plan_item(CMD_MOVE, 6, 0, 0);
        plan_item(CMD_ADD, 7, 0, 0);
        plan_item(CMD_MOVE, 6, 0, 0);
        plan_item(CMD_MOVE, 6, TOP_BUCKET, 0);
        plan_item(CMD_REMOVE, MEMBERS - 1, 0, 0);
        plan_item(CMD_MOVE, 7, 3 * LEVELS + 5, 0);
        plan_item(CMD_READ, 0, TOP_BUCKET, 0);
        plan_item(CMD_ADD, 682, 10 * LEVELS + 2, 170);
        plan_item(CMD_ADD, 341, 5 * LEVELS + 5, 85);
        directed_count = pending_requests.size();

        random_planned = 0;
        while (random_planned < RANDOM_ITEMS) begin
            if (!filled && random_planned >= FILL_AFTER) begin
                fill_bucket(hot_buckets[2]);
                filled = 1'b1;
            end else begin
                plan_random_item();
            end
            random_planned = pending_requests.size() - directed_count;
        end
        total_items = pending_requests.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_if.valid || predicted_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/bsri_pkg.sv
design/bsri_if.sv
design/bucketed_swap_remove_index_core.sv
tb/bucketed_swap_remove_index_core_tb.sv
